### rtl/edsch_pkg.sv
// Shared constants and types for the elevator disk scheduler.
// No dependencies; imported by the top level and edsch_scan.
package edsch_pkg;

  // Track table geometry
  localparam int TRACKS    = 1024;
  localparam int TRACK_W   = 10;
  localparam int ID_W      = 5;
  localparam int PEND_W    = 11;

  // Occupancy bitmap word width (default for the top-level parameter)
  localparam int WORD_BITS_DEF = 32;

  // Stream payload widths
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;

  // Reset value of the queue limit register
  localparam logic [PEND_W-1:0] QLIMIT_RST = PEND_W'(1024);

  // Result status codes
  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_OCCUPIED = 3'd2,
    ST_SERVED   = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

endpackage

### rtl/elevator_disk_scheduler.sv
// Elevator disk scheduler top level: control sequencer, bitmap and requester RAMs.
// Uses edsch_pkg, edsch_ram and edsch_scan.
//
// SCAN (elevator) request scheduler. Each input beat is a submit (tuser 0) or a
// service (tuser 1) command and yields exactly one result beat. Pending requests
// live in a requester RAM indexed by track plus an occupancy bitmap RAM of
// WORD_BITS-wide words. A submit reads the bitmap word, writes it back and loads
// the result; a submit refused for a full queue or a service on an empty table
// goes straight to the result load. A service walks the bitmap one word per cycle
// from the head word: first toward the current direction, then back from the head
// the other way, so it reads at most TRACKS/WORD_BITS + 1 words. A stalled result
// stream holds the sequencer in S_DONE. After reset a clearing pass writes every
// bitmap word before the first beat is taken; queue-limit writes on cfg_we are
// taken at any time. A finished result waits in the output register while the
// next command is accepted.
module elevator_disk_scheduler
  import edsch_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF  // power of two, 2 .. TRACKS/2
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [PEND_W-1:0]     cfg_data,      // queue_limit
  // command stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // track[9:0], requester_id[14:10]
  input  logic                  s_axis_tuser,  // cmd
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // served_track[9:0], served_requester[14:10], pending_now[25:15]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic [2:0]            m_axis_tuser   // status
);

  localparam int NWORDS = TRACKS / WORD_BITS;
  localparam int WIDX_W = $clog2(NWORDS);
  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(NWORDS - 1);
  localparam int PAD_W  = OUT_DATA_W - TRACK_W - ID_W - PEND_W;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SUB   = 6'b000100,
    S_SCAN  = 6'b001000,
    S_ID    = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t              state;
  logic [WIDX_W-1:0]   clr_ptr;
  logic [TRACK_W-1:0]  head;
  logic                up;
  logic [PEND_W-1:0]   count;
  logic [PEND_W-1:0]   qlimit;
  logic [TRACK_W-1:0]  trk_r;
  logic [ID_W-1:0]     who_r;
  logic [WIDX_W-1:0]   wptr;
  logic                phase_b;
  logic                first;
  status_t             res_status;
  logic [TRACK_W-1:0]  res_trk;
  logic [ID_W-1:0]     res_who;
  logic [2:0]          out_status;
  logic [TRACK_W-1:0]  out_trk;
  logic [ID_W-1:0]     out_who;
  logic [PEND_W-1:0]   out_pend;

  // memory ports
  logic                 bm_we;
  logic [WIDX_W-1:0]    bm_waddr;
  logic [WORD_BITS-1:0] bm_wdata;
  logic [WIDX_W-1:0]    bm_raddr;
  logic [WORD_BITS-1:0] bm_rdata;
  logic                 id_we;
  logic [TRACK_W-1:0]   id_raddr;
  logic [ID_W-1:0]      id_rdata;

  // input fields
  logic                 s_cmd;
  logic [TRACK_W-1:0]   s_trk;
  logic [ID_W-1:0]      s_who;
  logic                 in_beat;

  // scan helpers
  logic [WIDX_W-1:0]    head_word;
  logic                 dir_s;
  logic                 sc_hit;
  logic [BIT_W-1:0]     sc_idx;
  logic [TRACK_W-1:0]   found_trk;
  logic                 at_end;
  logic [WIDX_W-1:0]    nxt_word;
  logic [BIT_W-1:0]     trk_bit;

  assign s_cmd   = s_axis_tuser;
  assign s_trk   = s_axis_tdata[TRACK_W-1:0];
  assign s_who   = s_axis_tdata[TRACK_W+ID_W-1:TRACK_W];
  assign s_axis_tready = (state == S_IDLE);
  assign in_beat = s_axis_tvalid & s_axis_tready;

  assign head_word = head[TRACK_W-1:BIT_W];
  assign dir_s     = phase_b ? ~up : up;
  assign found_trk = {wptr, sc_idx};
  assign trk_bit   = trk_r[BIT_W-1:0];
  assign at_end    = dir_s ? (wptr == LAST_WORD) : (wptr == '0);
  assign nxt_word  = dir_s ? wptr + WIDX_W'(1) : wptr - WIDX_W'(1);

  assign m_axis_tdata = {{PAD_W{1'b0}}, out_pend, out_who, out_trk};
  assign m_axis_tuser = out_status;

  // occupancy bitmap, one bit per track
  edsch_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NWORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  // requester id per track, meaningful only where the bitmap bit is set
  edsch_ram #(
    .WIDTH (ID_W),
    .DEPTH (TRACKS)
  ) u_idmem (
    .clk   (clk),
    .we    (id_we),
    .waddr (trk_r),
    .wdata (who_r),
    .raddr (id_raddr),
    .rdata (id_rdata)
  );

  // search of the word arriving from the bitmap
  edsch_scan #(
    .WORD_BITS (WORD_BITS)
  ) u_scan (
    .data      (bm_rdata),
    .at_head   (wptr == head_word),
    .pos_bit   (head[BIT_W-1:0]),
    .dir_up    (dir_s),
    .check_pos (first),
    .hit       (sc_hit),
    .hit_idx   (sc_idx)
  );

  // memory control
  always_comb begin
    bm_we    = 1'b0;
    bm_waddr = wptr;
    bm_wdata = bm_rdata;
    bm_raddr = wptr;
    id_we    = 1'b0;
    id_raddr = found_trk;
    unique case (state)
      S_CLEAR: begin
        bm_we    = 1'b1;
        bm_waddr = clr_ptr;
        bm_wdata = '0;
      end
      S_IDLE: begin
        bm_raddr = s_cmd ? head_word : s_trk[TRACK_W-1:BIT_W];
      end
      S_SUB: begin
        bm_waddr = trk_r[TRACK_W-1:BIT_W];
        bm_wdata = bm_rdata | (WORD_BITS'(1) << trk_bit);
        if (!bm_rdata[trk_bit]) begin
          bm_we = 1'b1;
          id_we = 1'b1;
        end
      end
      S_SCAN: begin
        if (sc_hit) begin
          bm_we    = 1'b1;
          bm_wdata = bm_rdata & ~(WORD_BITS'(1) << sc_idx);
        end else if (at_end) begin
          bm_raddr = head_word;
        end else begin
          bm_raddr = nxt_word;
        end
      end
      S_ID, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // queue limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      qlimit <= QLIMIT_RST;
    end else if (cfg_we) begin
      qlimit <= cfg_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      out_status <= res_status;
      out_trk    <= res_trk;
      out_who    <= res_who;
      out_pend   <= count;
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_ptr <= '0;
      head    <= '0;
      up      <= 1'b1;
      count   <= '0;
      wptr    <= '0;
      phase_b <= 1'b0;
      first   <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_ptr <= clr_ptr + WIDX_W'(1);
          if (clr_ptr == LAST_WORD) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_beat) begin
            res_trk <= '0;
            res_who <= '0;
            trk_r   <= s_trk;
            who_r   <= s_who;
            if (!s_cmd) begin
              if (count >= qlimit) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else begin
                state <= S_SUB;
              end
            end else if (count == '0) begin
              res_status <= ST_EMPTY;
              state      <= S_DONE;
            end else begin
              wptr    <= head_word;
              phase_b <= 1'b0;
              first   <= 1'b1;
              state   <= S_SCAN;
            end
          end
        end
        S_SUB: begin
          if (bm_rdata[trk_bit]) begin
            res_status <= ST_OCCUPIED;
          end else begin
            res_status <= ST_ACCEPTED;
            count      <= count + PEND_W'(1);
          end
          state <= S_DONE;
        end
        S_SCAN: begin
          first <= 1'b0;
          if (sc_hit) begin
            head    <= found_trk;
            up      <= dir_s;
            count   <= count - PEND_W'(1);
            res_trk <= found_trk;
            state   <= S_ID;
          end else if (at_end) begin
            if (phase_b) begin
              // table and count disagree: report nothing pending
              res_status <= ST_EMPTY;
              state      <= S_DONE;
            end else begin
              phase_b <= 1'b1;
              wptr    <= head_word;
            end
          end else begin
            wptr <= nxt_word;
          end
        end
        S_ID: begin
          res_status <= ST_SERVED;
          res_who    <= id_rdata;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/edsch_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Depends on nothing; used for the occupancy bitmap and the requester table.
module edsch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/edsch_scan.sv
// Per-word search of one occupancy bitmap word relative to the head position.
// Uses edsch_pkg; instantiated by the top level scan sequencer.
module edsch_scan
  import edsch_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic [WORD_BITS-1:0]         data,
  input  logic                         at_head,   // word holds the head track
  input  logic [$clog2(WORD_BITS)-1:0] pos_bit,   // head bit inside the word
  input  logic                         dir_up,    // search toward higher tracks
  input  logic                         check_pos, // head track itself may hit
  output logic                         hit,
  output logic [$clog2(WORD_BITS)-1:0] hit_idx
);

  localparam int BIT_W = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] md;
  logic [WORD_BITS-1:0] rv;
  logic [WORD_BITS-1:0] iso_lo;
  logic [WORD_BITS-1:0] iso_hi;
  logic                 pos_hit;

  // one-hot to index, OR of independent bits
  function automatic logic [BIT_W-1:0] enc(input logic [WORD_BITS-1:0] oh);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (oh[i]) r = r | BIT_W'(i);
    end
    return r;
  endfunction

  // keep only bits beyond the head in the search direction
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      if (!at_head) begin
        mask[i] = 1'b1;
      end else if (dir_up) begin
        mask[i] = BIT_W'(i) > pos_bit;
      end else begin
        mask[i] = BIT_W'(i) < pos_bit;
      end
    end
  end

  assign md = data & mask;

  // bit-reversed copy so the highest set bit becomes the lowest
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      rv[i] = md[WORD_BITS-1-i];
    end
  end

  assign iso_lo  = md & (~md + WORD_BITS'(1));
  assign iso_hi  = rv & (~rv + WORD_BITS'(1));
  assign pos_hit = check_pos & data[pos_bit];

  // head track first, then nearest bit in the search direction
  always_comb begin
    hit = pos_hit | (|md);
    if (pos_hit) begin
      hit_idx = pos_bit;
    end else if (dir_up) begin
      hit_idx = enc(iso_lo);
    end else begin
      hit_idx = BIT_W'(WORD_BITS - 1) - enc(iso_hi);
    end
  end

endmodule
